/* src/iie_pkg.sv */
// iie_pkg: shared types for the i-type execute block
// holds the opcode enum and the input and result word structs
// no dependencies; imported by the top level and the checker
`timescale 1ns / 1ps

package iie_pkg;

  typedef enum logic [3:0] {
    OP_ADDI = 4'd0,
    OP_LW   = 4'd1,
    OP_LH   = 4'd2,
    OP_LHU  = 4'd3,
    OP_LB   = 4'd4,
    OP_LBU  = 4'd5,
    OP_SW   = 4'd6,
    OP_SH   = 4'd7,
    OP_SB   = 4'd8,
    OP_LUI  = 4'd9,
    OP_ANDI = 4'd10,
    OP_ORI  = 4'd11,
    OP_NORI = 4'd12,
    OP_SLTI = 4'd13,
    OP_BEQ  = 4'd14,
    OP_BNE  = 4'd15
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [4:0]         rs_index;
    logic [4:0]         rt_index;
    logic signed [15:0] immediate;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic               reg_written;
    logic signed [31:0] write_value;
    logic               write_zero_error;
    logic               number_overflow;
    logic               address_overflow;
    logic               misaligned;
    logic               halt;
  } out_word_t;

endpackage

/* src/itype_instruction_execute.sv */
// itype_instruction_execute: executes one i-type instruction per word
// uses iie_pkg for types and iie_ram for the register file copies and memory banks
`timescale 1ns / 1ps

// Usage
//   in_valid/in_stall/in_data carry one instruction word; out_valid/out_stall/
//   out_data carry one result word per instruction, in order.
//   cfg_wr_en/cfg_wr_data load the program counter (start pc); write it only
//   while no instruction is in flight.
// Pipeline and throughput
//   one instruction per cycle is accepted back to back while in_stall is low:
//   the register file is read at acceptance, address, alu and pc work in the
//   next cycle together with the store write or load read of the memory banks,
//   and load alignment plus register write-back in the cycle after, when the
//   result word is also written into the result buffer that feeds the output;
//   forwarding from the two later stages covers dependent instructions.
// Reset
//   the pc goes to zero and the register file reads as zero. The data memory
//   is then cleared one row of four bytes per cycle, all MEM_BYTES/4 rows,
//   while in_stall stays high; configuration writes are taken during that pass.
// Stalling
//   results queue in a four-word buffer; in_stall rises once that buffer plus the two
//   working stages hold four words, so new words are still taken while a result waits.
// MEM_BYTES must be a multiple of four.

module itype_instruction_execute
  import iie_pkg::*;
#(
  parameter int MEM_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int ROWS       = MEM_BYTES / 4;
  localparam int AW         = $clog2(MEM_BYTES);
  localparam int RW         = $clog2(ROWS);
  localparam int FIFO_DEPTH = 4;
  localparam int FPW        = $clog2(FIFO_DEPTH);

  // stage one registers
  logic        s1_v_r;
  opcode_t     s1_op_r;
  logic [4:0]  s1_rs_r;
  logic [4:0]  s1_rt_r;
  logic [15:0] s1_imm_r;

  // stage two registers
  logic        s2_v_r;
  opcode_t     s2_op_r;
  logic [4:0]  s2_rt_r;
  logic [1:0]  s2_lane_r;
  logic [31:0] s2_alu_r;
  logic        s2_wrote_r;
  logic [31:0] s2_pc_r;
  logic        s2_wz_r;
  logic        s2_novf_r;
  logic        s2_aovf_r;
  logic        s2_mis_r;
  logic        s2_halt_r;

  // architectural and support state
  logic [31:0] pc_r;
  logic [31:0] rf_valid_r;
  logic        byp_v_r;
  logic [4:0]  byp_addr_r;
  logic [31:0] byp_data_r;
  logic        clr_r;
  logic [RW-1:0] clr_row_r;

  // result buffer
  out_word_t        fifo_r [FIFO_DEPTH];
  logic [FPW-1:0]   wr_ptr_r;
  logic [FPW-1:0]   rd_ptr_r;
  logic [FPW:0]     cnt_r;

  logic        in_acc;
  logic        push;
  logic        pop;
  logic [FPW+1:0] occ;

  logic [31:0] rs_q;
  logic [31:0] rt_q;
  logic [31:0] base;
  logic [31:0] rtv;
  logic [31:0] imms;
  logic [31:0] immz;
  logic [31:0] sum;
  logic [2:0]  size;
  logic        is_store;
  logic        is_load;
  logic        is_branch;
  logic        is_arith;
  logic        writes;
  logic        wz;
  logic        novf;
  logic        aovf;
  logic        mis;
  logic        halt;
  logic        exec;
  logic        taken;
  logic [31:0] alu;
  logic [31:0] pc_nxt;
  logic [RW-1:0] s1_row;

  logic        st_we [4];
  logic [7:0]  st_wd [4];
  logic        bank_we [4];
  logic [RW-1:0] bank_wa;
  logic [7:0]  bank_wd [4];
  logic [7:0]  bank_rd [4];

  logic [31:0] ld_word;
  logic [15:0] ld_half;
  logic [7:0]  ld_byte;
  logic [31:0] s2_val;
  logic [31:0] s2_wval;
  logic        rf_we;
  out_word_t   s2_word;

  // handshake and buffer occupancy
  assign in_acc   = in_valid && !in_stall;
  assign occ      = (FPW+2)'(cnt_r) + (FPW+2)'(s1_v_r) + (FPW+2)'(s2_v_r);
  assign in_stall = !rst_n || clr_r || (occ >= (FPW+2)'(FIFO_DEPTH));
  assign push     = s2_v_r;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && !out_stall;
  assign out_data = fifo_r[rd_ptr_r];

  // register file, one copy per read port
  assign rf_we = s2_v_r && s2_wrote_r;

  iie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rs (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (s2_rt_r),
    .wr_data (s2_wval),
    .rd_addr (in_data.rs_index),
    .rd_data (rs_q)
  );

  iie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_rt (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (s2_rt_r),
    .wr_data (s2_wval),
    .rd_addr (in_data.rt_index),
    .rd_data (rt_q)
  );

  // base operand with forwarding from write-back and the last written word
  always_comb begin
    if (rf_we && (s2_rt_r == s1_rs_r)) begin
      base = s2_wval;
    end else if (byp_v_r && (byp_addr_r == s1_rs_r)) begin
      base = byp_data_r;
    end else if (rf_valid_r[s1_rs_r]) begin
      base = rs_q;
    end else begin
      base = '0;
    end
  end

  // second operand, same forwarding
  always_comb begin
    if (rf_we && (s2_rt_r == s1_rt_r)) begin
      rtv = s2_wval;
    end else if (byp_v_r && (byp_addr_r == s1_rt_r)) begin
      rtv = byp_data_r;
    end else if (rf_valid_r[s1_rt_r]) begin
      rtv = rt_q;
    end else begin
      rtv = '0;
    end
  end

  // opcode decode
  always_comb begin
    is_store  = 1'b0;
    is_load   = 1'b0;
    is_branch = 1'b0;
    is_arith  = 1'b1;
    size      = 3'd1;
    unique case (s1_op_r)
      OP_ADDI: ;
      OP_LW:   begin is_load = 1'b1; size = 3'd4; end
      OP_LH:   begin is_load = 1'b1; size = 3'd2; end
      OP_LHU:  begin is_load = 1'b1; size = 3'd2; end
      OP_LB:   is_load = 1'b1;
      OP_LBU:  is_load = 1'b1;
      OP_SW:   begin is_store = 1'b1; size = 3'd4; end
      OP_SH:   begin is_store = 1'b1; size = 3'd2; end
      OP_SB:   is_store = 1'b1;
      OP_BEQ:  begin is_branch = 1'b1; is_arith = 1'b0; end
      OP_BNE:  begin is_branch = 1'b1; is_arith = 1'b0; end
      OP_LUI, OP_ANDI, OP_ORI, OP_NORI, OP_SLTI: is_arith = 1'b0;
    endcase
  end

  // address, error flags and alu
  assign imms   = {{16{s1_imm_r[15]}}, s1_imm_r};
  assign immz   = {16'h0000, s1_imm_r};
  assign sum    = base + imms;
  assign writes = !is_store && !is_branch;
  assign wz     = writes && (s1_rt_r == 5'd0);
  assign novf   = is_arith && (~(base[31] ^ imms[31]) & (base[31] ^ sum[31]));
  assign aovf   = (is_load || is_store) &&
                  (sum[31] || ((33'(sum) + 33'(size)) > 33'(MEM_BYTES)));
  assign mis    = ((size == 3'd4) && (is_load || is_store) && (sum[1:0] != 2'b00)) ||
                  ((size == 3'd2) && (is_load || is_store) && sum[0]);
  assign halt   = aovf || mis;
  assign exec   = !wz && !halt;
  assign s1_row = sum[AW-1:2];

  always_comb begin
    alu   = '0;
    taken = 1'b0;
    unique case (s1_op_r)
      OP_ADDI: alu = sum;
      OP_LUI:  alu = {s1_imm_r, 16'h0000};
      OP_ANDI: alu = base & immz;
      OP_ORI:  alu = base | immz;
      OP_NORI: alu = ~(base | immz);
      OP_SLTI: alu = {31'd0, $signed(base) < $signed(imms)};
      OP_BEQ:  taken = (base == rtv);
      OP_BNE:  taken = (base != rtv);
      OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: ;
    endcase
  end

  // pc after this instruction
  assign pc_nxt = pc_r + 32'd4 + ((taken && exec) ? {imms[29:0], 2'b00} : 32'd0);

  // big-endian lane steering for stores
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      st_we[l] = 1'b0;
      st_wd[l] = '0;
    end
    if (s1_v_r && exec && is_store) begin
      unique case (s1_op_r)
        OP_SW: begin
          st_we[0] = 1'b1; st_wd[0] = rtv[31:24];
          st_we[1] = 1'b1; st_wd[1] = rtv[23:16];
          st_we[2] = 1'b1; st_wd[2] = rtv[15:8];
          st_we[3] = 1'b1; st_wd[3] = rtv[7:0];
        end
        OP_SH: begin
          st_we[{sum[1], 1'b0}] = 1'b1; st_wd[{sum[1], 1'b0}] = rtv[15:8];
          st_we[{sum[1], 1'b1}] = 1'b1; st_wd[{sum[1], 1'b1}] = rtv[7:0];
        end
        OP_SB: begin
          st_we[sum[1:0]] = 1'b1; st_wd[sum[1:0]] = rtv[7:0];
        end
        default: ;
      endcase
    end
  end

  // bank port muxing between the clearing pass and stores
  assign bank_wa = clr_r ? clr_row_r : s1_row;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    assign bank_we[g] = clr_r || st_we[g];
    assign bank_wd[g] = clr_r ? 8'h00 : st_wd[g];

    iie_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk     (clk),
      .wr_en   (bank_we[g]),
      .wr_addr (bank_wa),
      .wr_data (bank_wd[g]),
      .rd_addr (s1_row),
      .rd_data (bank_rd[g])
    );
  end

  // load alignment and write-back value
  assign ld_word = {bank_rd[0], bank_rd[1], bank_rd[2], bank_rd[3]};
  assign ld_half = s2_lane_r[1] ? {bank_rd[2], bank_rd[3]} : {bank_rd[0], bank_rd[1]};
  assign ld_byte = bank_rd[s2_lane_r];

  always_comb begin
    unique case (s2_op_r)
      OP_LW:   s2_val = ld_word;
      OP_LH:   s2_val = {{16{ld_half[15]}}, ld_half};
      OP_LHU:  s2_val = {16'h0000, ld_half};
      OP_LB:   s2_val = {{24{ld_byte[7]}}, ld_byte};
      OP_LBU:  s2_val = {24'h000000, ld_byte};
      default: s2_val = s2_alu_r;
    endcase
  end

  assign s2_wval = s2_wrote_r ? s2_val : 32'd0;

  always_comb begin
    s2_word.next_pc          = s2_pc_r;
    s2_word.reg_written      = s2_wrote_r;
    s2_word.write_value      = s2_wval;
    s2_word.write_zero_error = s2_wz_r;
    s2_word.number_overflow  = s2_novf_r;
    s2_word.address_overflow = s2_aovf_r;
    s2_word.misaligned       = s2_mis_r;
    s2_word.halt             = s2_halt_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      pc_r       <= '0;
      rf_valid_r <= '0;
      byp_v_r    <= 1'b0;
      clr_r      <= 1'b1;
      clr_row_r  <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      cnt_r      <= '0;
    end else begin
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r;
      byp_v_r <= rf_we;
      if (rf_we) begin
        rf_valid_r[s2_rt_r] <= 1'b1;
      end
      if (cfg_wr_en) begin
        pc_r <= cfg_wr_data;
      end else if (s1_v_r) begin
        pc_r <= pc_nxt;
      end
      if (clr_r) begin
        clr_row_r <= clr_row_r + 1'b1;
        if (clr_row_r == RW'(ROWS - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (FPW+1)'(push) - (FPW+1)'(pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_data.opcode;
      s1_rs_r  <= in_data.rs_index;
      s1_rt_r  <= in_data.rt_index;
      s1_imm_r <= in_data.immediate;
    end
    s2_op_r    <= s1_op_r;
    s2_rt_r    <= s1_rt_r;
    s2_lane_r  <= sum[1:0];
    s2_alu_r   <= alu;
    s2_wrote_r <= s1_v_r && exec && writes;
    s2_pc_r    <= pc_nxt;
    s2_wz_r    <= wz;
    s2_novf_r  <= novf;
    s2_aovf_r  <= aovf;
    s2_mis_r   <= mis;
    s2_halt_r  <= halt;
    byp_addr_r <= s2_rt_r;
    byp_data_r <= s2_wval;
    if (push) begin
      fifo_r[wr_ptr_r] <= s2_word;
    end
  end

endmodule

/* src/iie_ram.sv */
// iie_ram: generic single write port ram with one registered read port
// read during write to the same address returns the old contents
// no dependencies
`timescale 1ns / 1ps

module iie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* src/iie_checker.sv */
// iie_checker: port-level checks for the i-type execute block
// depends on iie_pkg; bound to itype_instruction_execute below
`timescale 1ns / 1ps

module iie_checker
  import iie_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // skipped instructions never report a register write
  a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.reg_written &&
                    (out_data.halt || out_data.write_zero_error)))
    else $error("register written by a skipped instruction");

  // no write means a zero value
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reg_written |-> out_data.write_value == 32'sd0)
    else $error("write value not zero without a write");

  // halt is exactly the address or alignment error
  a_halt_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.halt == (out_data.address_overflow || out_data.misaligned))
    else $error("halt does not match its causes");

  // memory clearing keeps the input closed right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open straight after reset");

endmodule

bind itype_instruction_execute iie_checker u_iie_checker (.*);
